// ===== sv/rsl_pkg.sv =====
// ----------------------------------------------------------------------------
// rsl_pkg: shared types and constants for the route slug locator
// Word formats of the byte and result channels, character codes, status codes.
// ----------------------------------------------------------------------------
package rsl_pkg;

  localparam int POS_W            = 10;
  localparam int MAX_PATH_LEN_DEF = 1024;
  localparam int DEPTH_BITS_DEF   = 8;

  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_LBRACE = 8'h7B;
  localparam logic [7:0] CHAR_COLON  = 8'h3A;
  localparam logic [7:0] CHAR_RBRACE = 8'h7D;

  typedef enum logic [1:0] {
    ST_EMPTY      = 2'd0,
    ST_FOUND      = 2'd1,
    ST_INCOMPLETE = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] path_byte;
    logic       last_byte;
  } byte_t;

  typedef struct packed {
    status_t          status;
    logic [POS_W-1:0] slug_begin;
    logic [POS_W-1:0] slug_len;
    logic             has_pattern;
    logic [POS_W-1:0] pattern_begin;
    logic [POS_W-1:0] pattern_span;
  } result_t;

endpackage

// ===== sv/route_slug_locator_top.sv =====
// ----------------------------------------------------------------------------
// route_slug_locator_top: locate the first brace slug in a route path
// Scans path bytes, tracks escapes and brace depth, reports one result word
// on the byte flagged last.
// ----------------------------------------------------------------------------
//  channel  | signals                          | word
//  ---------+----------------------------------+-------------------------------
//  byte     | byte_valid, byte_ready, byte_data     | rsl_pkg::byte_t
//  result   | result_valid, result_ready, result_data | rsl_pkg::result_t
//  cfg      | cfg_valid, cfg_ready, cfg_data        | start_offset, 10 bit
//
// One byte word per cycle. The scan state updates in the cycle the byte is
// taken; a last byte loads the result register and clears the scan state.
// A byte is taken while the result register is empty or being drained.
// Reset clears the scan state, start_offset and the result valid flag.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module route_slug_locator_top #(
  parameter int MAX_PATH_LEN = rsl_pkg::MAX_PATH_LEN_DEF,
  parameter int DEPTH_BITS   = rsl_pkg::DEPTH_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      byte_valid,
  output logic                      byte_ready,
  input  rsl_pkg::byte_t            byte_data,
  output logic                      result_valid,
  input  logic                      result_ready,
  output rsl_pkg::result_t          result_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [rsl_pkg::POS_W-1:0] cfg_data
);

  localparam int PCW   = $clog2(MAX_PATH_LEN + 1);
  localparam int CMP_W = (PCW > rsl_pkg::POS_W) ? PCW : rsl_pkg::POS_W;
  localparam int PW    = rsl_pkg::POS_W;

  localparam logic [CMP_W-1:0] MAX_POS = CMP_W'(MAX_PATH_LEN);
  localparam logic signed [DEPTH_BITS-1:0] DEPTH_MAX =
    {1'b0, {(DEPTH_BITS-1){1'b1}}};
  localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN =
    {1'b1, {(DEPTH_BITS-1){1'b0}}};
  localparam logic signed [DEPTH_BITS-1:0] DEPTH_ONE = DEPTH_BITS'(1);

  logic [PW-1:0]                start_offset;

  logic [PCW-1:0]               byte_position, byte_position_next;
  logic                         escape_pending, escape_pending_next;
  logic signed [DEPTH_BITS-1:0] brace_depth, brace_depth_next;
  logic                         depth_overflow, depth_overflow_next;
  logic                         slug_closed, slug_closed_next;
  logic [PW-1:0]                begin_position, begin_position_next;
  logic [PW-1:0]                end_position, end_position_next;
  logic                         pattern_seen, pattern_seen_next;
  logic [PW-1:0]                pattern_position, pattern_position_next;

  logic                         take;
  logic [CMP_W-1:0]             pos_ext;
  logic [PW-1:0]                pos_low;
  logic                         in_range;
  logic                         scan_en;
  logic [7:0]                   c;
  rsl_pkg::result_t             result_next;

  assign cfg_ready  = 1'b1;
  assign byte_ready = !result_valid || result_ready;
  assign take       = byte_valid && byte_ready;

  assign c        = byte_data.path_byte;
  assign pos_ext  = CMP_W'(byte_position);
  assign pos_low  = pos_ext[PW-1:0];
  assign in_range = pos_ext < MAX_POS;
  assign scan_en  = in_range && (pos_ext >= CMP_W'(start_offset))
                    && !slug_closed && !depth_overflow;

  always_comb begin
    byte_position_next    = in_range ? byte_position + PCW'(1) : byte_position;
    escape_pending_next   = escape_pending;
    brace_depth_next      = brace_depth;
    depth_overflow_next   = depth_overflow;
    slug_closed_next      = slug_closed;
    begin_position_next   = begin_position;
    end_position_next     = end_position;
    pattern_seen_next     = pattern_seen;
    pattern_position_next = pattern_position;

    if (scan_en) begin
      if (escape_pending) begin
        escape_pending_next = 1'b0;
      end else if (c == rsl_pkg::CHAR_BSLASH) begin
        escape_pending_next = 1'b1;
      end else if (brace_depth == '0 && c == rsl_pkg::CHAR_LBRACE) begin
        begin_position_next = pos_low + PW'(1);
        brace_depth_next    = DEPTH_ONE;
      end else if (brace_depth == DEPTH_ONE && c == rsl_pkg::CHAR_COLON) begin
        pattern_position_next = pos_low + PW'(1);
        pattern_seen_next     = 1'b1;
      end else if (brace_depth == DEPTH_ONE && c == rsl_pkg::CHAR_RBRACE) begin
        end_position_next = pos_low;
        slug_closed_next  = 1'b1;
        brace_depth_next  = '0;
      end else if (c == rsl_pkg::CHAR_LBRACE) begin
        // saturate at the signed limits and flag it
        if (brace_depth == DEPTH_MAX) begin
          depth_overflow_next = 1'b1;
        end else begin
          brace_depth_next = brace_depth + DEPTH_ONE;
        end
      end else if (c == rsl_pkg::CHAR_RBRACE) begin
        if (brace_depth == DEPTH_MIN) begin
          depth_overflow_next = 1'b1;
        end else begin
          brace_depth_next = brace_depth - DEPTH_ONE;
        end
      end
    end
  end

  always_comb begin
    result_next = '0;
    if (depth_overflow_next) begin
      result_next.status = rsl_pkg::ST_INCOMPLETE;
    end else if (slug_closed_next) begin
      result_next.status     = rsl_pkg::ST_FOUND;
      result_next.slug_begin = begin_position_next;
      result_next.slug_len   = end_position_next - begin_position_next;
      if (pattern_seen_next) begin
        result_next.has_pattern   = 1'b1;
        result_next.pattern_begin = pattern_position_next;
        result_next.pattern_span  = end_position_next - pattern_position_next;
      end
    end else if (brace_depth_next != '0) begin
      result_next.status = rsl_pkg::ST_INCOMPLETE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_offset <= '0;
    end else if (cfg_valid && cfg_ready) begin
      start_offset <= cfg_data;
    end
  end

  // scan state: advance on each byte, drop back to reset after the last one
  always_ff @(posedge clk) begin
    if (rst || (take && byte_data.last_byte)) begin
      byte_position    <= '0;
      escape_pending   <= 1'b0;
      brace_depth      <= '0;
      depth_overflow   <= 1'b0;
      slug_closed      <= 1'b0;
      begin_position   <= '0;
      end_position     <= '0;
      pattern_seen     <= 1'b0;
      pattern_position <= '0;
    end else if (take) begin
      byte_position    <= byte_position_next;
      escape_pending   <= escape_pending_next;
      brace_depth      <= brace_depth_next;
      depth_overflow   <= depth_overflow_next;
      slug_closed      <= slug_closed_next;
      begin_position   <= begin_position_next;
      end_position     <= end_position_next;
      pattern_seen     <= pattern_seen_next;
      pattern_position <= pattern_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take && byte_data.last_byte) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && byte_data.last_byte) begin
      result_data <= result_next;
    end
  end

endmodule

// ===== tb/sv/rsl_scan_checker.sv =====
// ----------------------------------------------------------------------------
// rsl_scan_checker: scoreboard for the route slug locator
// Watches the byte, result and cfg channels, keeps its own copy of the scan
// state, queues the result word each last byte should give and compares
// every accepted result word with the oldest one, field by field.
// ----------------------------------------------------------------------------
module rsl_scan_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      byte_valid,
  input  logic                      byte_ready,
  input  rsl_pkg::byte_t            byte_data,
  input  logic                      result_valid,
  input  logic                      result_ready,
  input  rsl_pkg::result_t          result_data,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [rsl_pkg::POS_W-1:0] cfg_data,
  output int                        errors,
  output int                        pending
);

  localparam int PW       = rsl_pkg::POS_W;
  localparam int DEPTH_HI = 2 ** (rsl_pkg::DEPTH_BITS_DEF - 1) - 1;
  localparam int DEPTH_LO = -DEPTH_HI - 1;

  logic [PW-1:0]    first_pos;
  int unsigned      scan_pos;
  logic             esc_armed;
  int               depth;
  logic             depth_sat;
  logic             closed;
  logic [PW-1:0]    open_at;
  logic [PW-1:0]    close_at;
  logic             pat_mark;
  logic [PW-1:0]    pat_at;
  int               err_n = 0;
  rsl_pkg::result_t expected_results[$];

  function automatic void clear_scan();
    scan_pos  = 0;
    esc_armed = 1'b0;
    depth     = 0;
    depth_sat = 1'b0;
    closed    = 1'b0;
    open_at   = '0;
    close_at  = '0;
    pat_mark  = 1'b0;
    pat_at    = '0;
  endfunction

  // saturate at the signed limits of the depth counter
  function automatic void bump_depth(int delta);
    int d;
    d = depth + delta;
    if (d > DEPTH_HI) begin
      d = DEPTH_HI;
      depth_sat = 1'b1;
    end else if (d < DEPTH_LO) begin
      d = DEPTH_LO;
      depth_sat = 1'b1;
    end
    depth = d;
  endfunction

  task automatic take_path_byte(input rsl_pkg::byte_t w);
    int unsigned      here;
    logic [7:0]       c;
    rsl_pkg::result_t r;
    here = scan_pos;
    c    = w.path_byte;
    if (here < rsl_pkg::MAX_PATH_LEN_DEF) begin
      if (here >= first_pos && !closed && !depth_sat) begin
        if (esc_armed) begin
          esc_armed = 1'b0;
        end else if (c == rsl_pkg::CHAR_BSLASH) begin
          esc_armed = 1'b1;
        end else if (depth == 0 && c == rsl_pkg::CHAR_LBRACE) begin
          open_at = PW'(here + 1);
          bump_depth(1);
        end else if (depth == 1 && c == rsl_pkg::CHAR_COLON) begin
          pat_at   = PW'(here + 1);
          pat_mark = 1'b1;
        end else if (depth == 1 && c == rsl_pkg::CHAR_RBRACE) begin
          close_at = PW'(here);
          closed   = 1'b1;
          depth    = 0;
        end else if (c == rsl_pkg::CHAR_LBRACE) begin
          bump_depth(1);
        end else if (c == rsl_pkg::CHAR_RBRACE) begin
          bump_depth(-1);
        end
      end
      scan_pos = here + 1;
    end
    if (w.last_byte) begin
      r = '0;
      if (depth_sat) begin
        r.status = rsl_pkg::ST_INCOMPLETE;
      end else if (closed) begin
        r.status     = rsl_pkg::ST_FOUND;
        r.slug_begin = open_at;
        r.slug_len   = close_at - open_at;
        if (pat_mark) begin
          r.has_pattern   = 1'b1;
          r.pattern_begin = pat_at;
          r.pattern_span  = close_at - pat_at;
        end
      end else if (depth != 0) begin
        r.status = rsl_pkg::ST_INCOMPLETE;
      end else begin
        r.status = rsl_pkg::ST_EMPTY;
      end
      expected_results.push_back(r);
      clear_scan();
    end
  endtask

  task automatic compare_field(input string fname, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      err_n++;
    end
  endtask

  always @(posedge clk) begin
    rsl_pkg::result_t want;
    if (rst) begin
      clear_scan();
      first_pos = '0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) first_pos = cfg_data;
      if (byte_valid && byte_ready) take_path_byte(byte_data);
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          $error("result word with no expected result: %h", result_data);
          err_n++;
        end else begin
          want = expected_results.pop_front();
          compare_field("status", want.status, result_data.status);
          compare_field("slug_begin", want.slug_begin, result_data.slug_begin);
          compare_field("slug_len", want.slug_len, result_data.slug_len);
          compare_field("has_pattern", want.has_pattern, result_data.has_pattern);
          compare_field("pattern_begin", want.pattern_begin,
                        result_data.pattern_begin);
          compare_field("pattern_span", want.pattern_span,
                        result_data.pattern_span);
        end
      end
    end
    errors  <= err_n;
    pending <= expected_results.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for route_slug_locator_top
// Drives route paths byte by byte under several start offsets and idle
// patterns: a few hand-made paths, then mostly well-formed slugs with random
// content, noise and deep brace runs.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int PW          = rsl_pkg::POS_W;
  localparam int STALL_LIMIT = 3000;
  localparam int PHASE_ITEMS = 270;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;

  logic             clk;
  logic             rst          = 1'b1;
  logic             byte_valid   = 1'b0;
  logic             byte_ready;
  rsl_pkg::byte_t   byte_data    = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  rsl_pkg::result_t result_data;
  logic             cfg_valid    = 1'b0;
  logic             cfg_ready;
  logic [PW-1:0]    cfg_data     = '0;

  int               errors;
  int               pending;
  int unsigned      send_idle    = 12;
  int unsigned      recv_idle    = 78;
  int               stall_run    = 0;
  logic [7:0]       path_q[$];

  route_slug_locator_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_data    (byte_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  rsl_scan_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_data    (byte_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    result_ready <= ($urandom_range(99) >= recv_idle);
  end

  // end the run when no word moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (byte_valid && byte_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_run <= 0;
    end else begin
      stall_run <= stall_run + 1;
      if (stall_run >= STALL_LIMIT) begin
        $display("FAIL route_slug_locator_top");
        $finish;
      end
    end
  end

  function automatic logic [7:0] plain_char();
    if ($urandom_range(7) == 0) return CHAR_SLASH;
    return CHAR_LOWER_A + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) return rsl_pkg::CHAR_LBRACE;
    if (r < 35) return rsl_pkg::CHAR_RBRACE;
    if (r < 45) return rsl_pkg::CHAR_COLON;
    if (r < 53) return rsl_pkg::CHAR_BSLASH;
    if (r < 80) return plain_char();
    return 8'($urandom_range(255));
  endfunction

  task automatic send_path();
    rsl_pkg::byte_t w;
    for (int i = 0; i < path_q.size(); i++) begin
      while ($urandom_range(99) < send_idle) begin
        byte_valid <= 1'b0;
        @(posedge clk);
      end
      w.path_byte = path_q[i];
      w.last_byte = (i == path_q.size() - 1);
      byte_valid <= 1'b1;
      byte_data  <= w;
      do @(posedge clk); while (!byte_ready);
    end
  endtask

  task automatic send_text(input string s);
    path_q.delete();
    for (int i = 0; i < s.len(); i++) path_q.push_back(s[i]);
    send_path();
  endtask

  task automatic run_random(input int unsigned quota);
    int unsigned sent;
    int unsigned r;
    int unsigned n;
    sent = 0;
    while (sent < quota) begin
      path_q.delete();
      r = $urandom_range(99);
      if (r < 55) begin
        // prefix, slug name with optional escapes, optional pattern, usually a close, suffix
        n = $urandom_range(0, 6);
        repeat (n) path_q.push_back(plain_char());
        path_q.push_back(rsl_pkg::CHAR_LBRACE);
        n = $urandom_range(0, 4);
        repeat (n) begin
          if ($urandom_range(9) == 0) path_q.push_back(rsl_pkg::CHAR_BSLASH);
          path_q.push_back($urandom_range(4) == 0 ? pick_char() : plain_char());
        end
        if ($urandom_range(1)) begin
          path_q.push_back(rsl_pkg::CHAR_COLON);
          n = $urandom_range(0, 5);
          repeat (n) path_q.push_back(pick_char());
        end
        if ($urandom_range(9) != 0) path_q.push_back(rsl_pkg::CHAR_RBRACE);
        n = $urandom_range(0, 4);
        repeat (n) path_q.push_back(pick_char());
      end else if (r < 95) begin
        n = $urandom_range(1, 16);
        repeat (n) path_q.push_back(pick_char());
      end else if (r < 97) begin
        // straddle the positive depth limit
        n = $urandom_range(126, 132);
        repeat (n) path_q.push_back(rsl_pkg::CHAR_LBRACE);
        n = $urandom_range(0, 3);
        repeat (n) path_q.push_back(pick_char());
      end else begin
        n = $urandom_range(127, 131);
        repeat (n) path_q.push_back(rsl_pkg::CHAR_RBRACE);
        n = $urandom_range(0, 3);
        repeat (n) path_q.push_back(pick_char());
      end
      sent += path_q.size();
      send_path();
    end
  endtask

  task automatic set_offset(input logic [PW-1:0] v);
    byte_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // hand-made paths under the reset offset
    send_text("{a:b:}");
    send_text("\\{\\}");
    send_text("}");
    path_q = '{8'h00, 8'hFF, rsl_pkg::CHAR_BSLASH};
    send_path();
    send_text("}{{a}");
    send_text("{");

    set_offset(PW'($urandom_range(1, 6)));
    run_random(PHASE_ITEMS);

    set_offset('0);
    send_idle = 78;
    recv_idle <= 12;
    run_random(PHASE_ITEMS);

    set_offset('1);
    send_idle = 0;
    recv_idle <= 0;
    send_text("{a}");
    set_offset(PW'($urandom_range(0, 3)));
    run_random(PHASE_ITEMS);

    byte_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASS route_slug_locator_top");
    end else begin
      $display("FAIL route_slug_locator_top");
    end
    $finish;
  end

endmodule
